### hdl/dab_pkg.sv
// Shared types and constants for the deduplicating aligned bump allocator.
// Holds the request and response payloads, the table entry layout, the controller
// states and the command and status bundles. Depends on nothing.
`default_nettype none

package dab_pkg;

  // Default depth of the entry table.
  localparam int MAX_ENTRIES_DEF = 64;

  // Field widths fixed by the block's interface.
  localparam int TypeIdW   = 16;
  localparam int AddrW     = 32;
  localparam int CountW    = 16;
  localparam int AlignW    = 3;
  localparam int ElemSizeW = 13;
  localparam int OffsetW   = 36;
  localparam int IndexW    = 6;
  localparam int ProdW     = ElemSizeW + CountW;
  localparam int BufSizeW  = 32;
  localparam int CfgDataW  = 32;
  localparam int CfgIdxW   = 1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_BUFFER_SIZE    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BUFFER_ENABLED = 1'b1;

  typedef struct packed {
    logic [TypeIdW-1:0]   dest_type_id;
    logic [TypeIdW-1:0]   source_type_id;
    logic [AddrW-1:0]     source_address;
    logic [CountW-1:0]    element_count;
    logic [AlignW-1:0]    align_log2;
    logic [ElemSizeW-1:0] element_size;
  } req_t;

  typedef struct packed {
    logic [OffsetW-1:0] block_offset;
    logic               offset_valid;
    logic               was_found;
    logic [IndexW-1:0]  entry_index;
    logic               table_full;
  } rsp_t;

  typedef struct packed {
    logic [2*TypeIdW-1:0] types;
    logic [AddrW-1:0]     source;
    logic [CountW-1:0]    count;
    logic [OffsetW-1:0]   offset;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ROUND,
    ST_APPEND,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted request and restart the scan
    logic scan;       // issue a table read at the scan pointer
    logic take_hit;   // build the result from the matching entry
    logic take_full;  // build the table-full result
    logic round;      // align the running offset and form size times count
    logic append;     // write the new entry and advance the running offset
    logic emit;       // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hit;        // the entry read last cycle matches the request
    logic scan_done;  // every stored entry has been read
    logic table_full; // no free entry is left
    logic out_free;   // the output register can take a result this cycle
  } dp_status_t;

endpackage

`default_nettype wire

### hdl/dab_ifs.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on dab_pkg for the payload types.
`default_nettype none

interface dab_req_if;
  logic          valid;
  logic          ready;
  dab_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dab_rsp_if;
  logic          valid;
  logic          ready;
  dab_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/dab_ctrl.sv
// Controller state machine of the allocator: sequences accept, scan, round, append and output.
// Depends on dab_pkg for the state, command and status types.
`default_nettype none

module dab_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dab_pkg::dp_status_t status,
  output dab_pkg::dp_cmd_t         cmd
);

  dab_pkg::state_t state_r;
  dab_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dab_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dab_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dab_pkg::ST_SCAN;
        end
      end
      dab_pkg::ST_SCAN: begin
        if (status.hit) begin
          state_nxt = dab_pkg::ST_OUT;
        end else if (status.scan_done) begin
          state_nxt = status.table_full ? dab_pkg::ST_OUT : dab_pkg::ST_ROUND;
        end
      end
      dab_pkg::ST_ROUND:  state_nxt = dab_pkg::ST_APPEND;
      dab_pkg::ST_APPEND: state_nxt = dab_pkg::ST_OUT;
      dab_pkg::ST_OUT: begin
        if (status.out_free) begin
          state_nxt = dab_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dab_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      dab_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      dab_pkg::ST_SCAN: begin
        if (status.hit) begin
          cmd.take_hit = 1'b1;
        end else if (status.scan_done) begin
          cmd.take_full = status.table_full;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      dab_pkg::ST_ROUND:  cmd.round = 1'b1;
      dab_pkg::ST_APPEND: cmd.append = 1'b1;
      dab_pkg::ST_OUT:    cmd.emit = status.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/dab_datapath.sv
// Datapath of the allocator: entry table memory, scan pointer, key compare,
// alignment and advance arithmetic, configuration registers and output register.
// Depends on dab_pkg and the channel interfaces in dab_ifs.
`default_nettype none

module dab_datapath #(
  parameter int MAX_ENTRIES = dab_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire dab_pkg::req_t                      in_data,
  dab_rsp_if.source                               out_rsp,
  input  wire logic                               cfg_we,
  input  wire logic [dab_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [dab_pkg::CfgDataW-1:0]       cfg_wdata,
  input  wire dab_pkg::dp_cmd_t                   cmd,
  output dab_pkg::dp_status_t                     status
);

  localparam int IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int OffW = dab_pkg::OffsetW;
  localparam int PrW  = dab_pkg::ProdW;

  // Entry table, one write and one registered read per cycle.
  dab_pkg::entry_t mem [MAX_ENTRIES];
  dab_pkg::entry_t rd_data_r;

  dab_pkg::req_t   req_r;
  logic [CntW-1:0] scan_r;
  logic [CntW-1:0] used_r;
  logic [IdxW-1:0] rd_idx_r;
  logic            rd_vld_r;
  logic [OffW-1:0] run_r;
  logic [OffW-1:0] rounded_r;
  logic [PrW-1:0]  prod_r;
  dab_pkg::rsp_t   res_r;
  dab_pkg::rsp_t   out_data_r;
  logic            out_valid_r;
  logic [dab_pkg::BufSizeW-1:0] buf_size_r;
  logic            buf_en_r;

  logic [OffW:0]   align_m1;
  logic [OffW:0]   round_sum;
  logic [OffW:0]   round_masked;
  logic [OffW-1:0] rounded_nxt;
  logic [OffW:0]   adv_sum;
  logic [OffW-1:0] run_nxt;
  logic            key_match;
  logic            offset_ok;
  logic [IdxW+dab_pkg::IndexW-1:0] hit_idx_ext;
  logic [IdxW+dab_pkg::IndexW-1:0] new_idx_ext;
  dab_pkg::entry_t new_entry;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r <= '0;
      buf_en_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dab_pkg::CFG_BUFFER_SIZE:    buf_size_r <= cfg_wdata[dab_pkg::BufSizeW-1:0];
        dab_pkg::CFG_BUFFER_ENABLED: buf_en_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Rounding up to the alignment, with saturation at the top of the offset range.
  always_comb begin
    align_m1     = ((OffW+1)'(1) << req_r.align_log2) - (OffW+1)'(1);
    round_sum    = {1'b0, run_r} + align_m1;
    round_masked = round_sum & ~align_m1;
    rounded_nxt  = round_masked[OffW] ? '1 : round_masked[OffW-1:0];
    adv_sum      = {1'b0, rounded_r} + (OffW+1)'(prod_r);
    run_nxt      = adv_sum[OffW] ? '1 : adv_sum[OffW-1:0];
  end

  assign key_match = (rd_data_r.types  == {req_r.dest_type_id, req_r.source_type_id}) &&
                     (rd_data_r.source == req_r.source_address) &&
                     (rd_data_r.count  == req_r.element_count);

  assign hit_idx_ext = {{dab_pkg::IndexW{1'b0}}, rd_idx_r};
  assign new_idx_ext = {{dab_pkg::IndexW{1'b0}}, used_r[IdxW-1:0]};
  assign offset_ok   = buf_en_r && !res_r.table_full &&
                       (run_r <= OffW'(buf_size_r));

  assign new_entry.types  = {req_r.dest_type_id, req_r.source_type_id};
  assign new_entry.source = req_r.source_address;
  assign new_entry.count  = req_r.element_count;
  assign new_entry.offset = rounded_r;

  // Table memory.
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[used_r[IdxW-1:0]] <= new_entry;
    end
    if (cmd.scan) begin
      rd_data_r <= mem[scan_r[IdxW-1:0]];
    end
  end

  // Control counters and allocator state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      used_r   <= '0;
      rd_vld_r <= 1'b0;
      run_r    <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        scan_r <= '0;
      end else if (cmd.scan) begin
        scan_r <= scan_r + CntW'(1);
      end
      if (cmd.append) begin
        used_r <= used_r + CntW'(1);
        run_r  <= run_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.scan) begin
      rd_idx_r <= scan_r[IdxW-1:0];
    end
    if (cmd.round) begin
      rounded_r <= rounded_nxt;
      prod_r    <= PrW'(req_r.element_size) * PrW'(req_r.element_count);
    end
    if (cmd.take_hit) begin
      res_r.block_offset <= rd_data_r.offset;
      res_r.offset_valid <= 1'b0;
      res_r.was_found    <= 1'b1;
      res_r.entry_index  <= hit_idx_ext[dab_pkg::IndexW-1:0];
      res_r.table_full   <= 1'b0;
    end else if (cmd.take_full) begin
      res_r.block_offset <= '0;
      res_r.offset_valid <= 1'b0;
      res_r.was_found    <= 1'b0;
      res_r.entry_index  <= '0;
      res_r.table_full   <= 1'b1;
    end else if (cmd.append) begin
      res_r.block_offset <= rounded_r;
      res_r.offset_valid <= 1'b0;
      res_r.was_found    <= 1'b0;
      res_r.entry_index  <= new_idx_ext[dab_pkg::IndexW-1:0];
      res_r.table_full   <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r.block_offset <= res_r.block_offset;
      out_data_r.offset_valid <= offset_ok;
      out_data_r.was_found    <= res_r.was_found;
      out_data_r.entry_index  <= res_r.entry_index;
      out_data_r.table_full   <= res_r.table_full;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  assign status.hit        = rd_vld_r && key_match;
  assign status.scan_done  = (scan_r == used_r);
  assign status.table_full = (used_r == CntW'(MAX_ENTRIES));
  assign status.out_free   = !out_valid_r || out_rsp.ready;

  // The table never holds more entries than it has room for.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CntW'(MAX_ENTRIES))
    else $error("entry count exceeds table depth");

  // An append only happens with a free entry, and it adds exactly one entry.
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !status.table_full)
    else $error("append into a full table");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |=> used_r == $past(used_r) + CntW'(1))
    else $error("append did not add one entry");

  // The running offset only moves forward.
  a_run_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> run_r >= $past(run_r))
    else $error("running offset decreased");

  // A table-full result carries no offset and is never valid.
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.table_full) |->
      (out_data_r.block_offset == '0 && !out_data_r.offset_valid &&
       !out_data_r.was_found))
    else $error("table-full result carries data");

endmodule

`default_nettype wire

### hdl/dedup_aligned_bump_allocator.sv
// Top level of the deduplicating aligned bump allocator.
// Instantiates dab_ctrl and dab_datapath; depends on dab_pkg and the channel
// interfaces in dab_ifs.
`default_nettype none

// Each request transaction carries four match keys (destination type id, source
// type id, source address, element count) plus an alignment exponent and an
// element size. The block scans its entry table oldest first for an entry whose
// four keys all match. On a hit it returns that entry's offset with was_found set.
// On a miss it rounds the running offset up to the requested alignment, stores the
// result as a new entry, returns it with the new entry's index, and advances the
// running offset by element size times element count; both values saturate at the
// top of the 36-bit offset range. offset_valid is set when the buffer is enabled
// and the running offset does not exceed buffer_size. When the table is already
// full a miss returns table_full with all other fields zero and changes nothing.
// The block works on one request at a time. On a hit the scan stops at the matching
// entry and the block goes straight to its output state; a miss reads every stored
// entry and then passes through the round and append states before its result is
// loaded into the output register. The table sits in a memory with one registered
// read port; the scan reads one entry per cycle, comparing it in the following
// cycle. A miss against a full table returns table_full once the scan is done.
// After a result is loaded into the output register, the block returns to idle and
// accepts the next request in the cycle after; a result still waiting there holds
// the block in its output state until the receiver takes it. A waiting result does
// not hold up acceptance of the next request, only the loading of that request's
// result.
// Configuration writes (register 0 buffer_size, register 1 buffer_enabled) are
// taken on any cycle with cfg_we high and must only be issued while the block is
// idle.
module dedup_aligned_bump_allocator #(
  parameter int MAX_ENTRIES = dab_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  dab_req_if.sink                           in_req,
  dab_rsp_if.source                         out_rsp,
  input  wire logic                         cfg_we,
  input  wire logic [dab_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [dab_pkg::CfgDataW-1:0] cfg_wdata
);

  dab_pkg::dp_cmd_t    cmd;
  dab_pkg::dp_status_t status;
  logic                in_ready;

  // The controller only raises ready while idle, so a transaction is accepted
  // exactly when it issues the load command.
  assign in_req.ready = in_ready;

  dab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dab_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_req.data),
    .out_rsp   (out_rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
